/* hdl/lzoq_pkg.sv */
package lzoq_pkg;

   // Fixed sizes
   localparam int NUM_CHANNELS        = 8;
   localparam int HISTORY_LEN_DEFAULT = 8;
   localparam int FRONT_AREA_MAX      = 31;

   // Register indexes (address bit 2 of the configuration port)
   localparam logic REG_HOLD_THRESHOLD = 1'b0;
   localparam logic REG_SIDES_ENABLED  = 1'b1;

   // Reset values
   localparam logic [4:0] HOLD_THRESHOLD_RESET = 5'd25;
   localparam logic [1:0] SIDES_ENABLED_RESET  = 2'b11;
   localparam logic [7:0] AREA_NONE            = 8'hFF;
   localparam logic [3:0] BACK_PINS_RESET      = 4'hF;
   localparam logic [4:0] FRONT_PINS_RESET     = 5'h1F;

   // Which scanners are in use
   typedef struct packed {
      logic use_front;
      logic use_back;
   } side_ctrl_type;

endpackage

/* hdl/lzoq_area.sv */
module lzoq_area (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  lzoq_pkg::side_ctrl_type side,
   input  logic [7:0]             area_command,
   output logic [3:0]             back_pins_in,
   output logic [4:0]             front_pins_in,
   output logic [1:0]             area_changed_in
);

   logic [7:0] last_back_ff, last_back_in;
   logic [7:0] last_front_ff, last_front_in;
   logic [3:0] back_pins_ff;
   logic [4:0] front_pins_ff;
   logic [3:0] back_area;
   logic [5:0] front_sum;
   logic [5:0] front_area;

   // Area numbers from the packed command
   always_comb begin
      back_area = {1'b0, area_command[2:0]} + 4'd1;
      front_sum = {1'b0, area_command[7:3]} + 6'd1;
      if (front_sum > 6'(lzoq_pkg::FRONT_AREA_MAX)) begin
         front_area = 6'd1;
      end else begin
         front_area = front_sum;
      end
   end

   // Pins are rewritten only on a change and only for a side in use
   always_comb begin
      last_back_in    = last_back_ff;
      last_front_in   = last_front_ff;
      back_pins_in    = back_pins_ff;
      front_pins_in   = front_pins_ff;
      area_changed_in = 2'b00;
      if ({4'd0, back_area} != last_back_ff) begin
         last_back_in = {4'd0, back_area};
         if (side.use_back) begin
            back_pins_in       = ~back_area;
            area_changed_in[0] = 1'b1;
         end
      end
      if ({2'd0, front_area} != last_front_ff) begin
         last_front_in = {2'd0, front_area};
         if (side.use_front) begin
            front_pins_in      = ~front_area[4:0];
            area_changed_in[1] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_back_ff  <= lzoq_pkg::AREA_NONE;
         last_front_ff <= lzoq_pkg::AREA_NONE;
         back_pins_ff  <= lzoq_pkg::BACK_PINS_RESET;
         front_pins_ff <= lzoq_pkg::FRONT_PINS_RESET;
      end else if (accept) begin
         last_back_ff  <= last_back_in;
         last_front_ff <= last_front_in;
         back_pins_ff  <= back_pins_in;
         front_pins_ff <= front_pins_in;
      end
   end

endmodule

/* hdl/lzoq_fail.sv */
module lzoq_fail #(
   parameter int HISTORY_LEN = lzoq_pkg::HISTORY_LEN_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  lzoq_pkg::side_ctrl_type side,
   input  logic [1:0]             trouble_lines,
   input  logic [1:0]             clear_latch,
   output logic [1:0]             failure_level_in,
   output logic [1:0]             fail_latch_in
);

   logic [HISTORY_LEN-1:0] hist_back_ff, hist_back_in;
   logic [HISTORY_LEN-1:0] hist_front_ff, hist_front_in;
   logic [1:0]             failure_level_ff;
   logic [1:0]             fail_latch_ff;
   logic [1:0]             latch_cleared;

   // Trouble pins of an unused side shift in as zero
   always_comb begin
      hist_back_in  = {hist_back_ff[HISTORY_LEN-2:0], side.use_back & trouble_lines[0]};
      hist_front_in = {hist_front_ff[HISTORY_LEN-2:0], side.use_front & trouble_lines[1]};
   end

   // Clear first, then a full history sets level and sticky flag, an empty one clears level
   always_comb begin
      latch_cleared    = fail_latch_ff & ~clear_latch;
      fail_latch_in    = latch_cleared;
      failure_level_in = failure_level_ff;
      if (&hist_back_in) begin
         fail_latch_in[0]    = 1'b1;
         failure_level_in[0] = 1'b1;
      end else if (~|hist_back_in) begin
         failure_level_in[0] = 1'b0;
      end
      if (&hist_front_in) begin
         fail_latch_in[1]    = 1'b1;
         failure_level_in[1] = 1'b1;
      end else if (~|hist_front_in) begin
         failure_level_in[1] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_back_ff     <= '0;
         hist_front_ff    <= '0;
         failure_level_ff <= 2'b00;
         fail_latch_ff    <= 2'b00;
      end else if (accept) begin
         hist_back_ff     <= hist_back_in;
         hist_front_ff    <= hist_front_in;
         failure_level_ff <= failure_level_in;
         fail_latch_ff    <= fail_latch_in;
      end
   end

endmodule

/* hdl/lzoq_hold.sv */
module lzoq_hold (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  lzoq_pkg::side_ctrl_type              side,
   input  logic [4:0]                          threshold,
   input  logic [2:0]                          back_zones,
   input  logic [2:0]                          front_zones,
   input  logic [1:0]                          fail_latch,
   output logic [lzoq_pkg::NUM_CHANNELS-1:0]   sensor_in
);

   localparam int N = lzoq_pkg::NUM_CHANNELS;

   logic [4:0]   count_ff [N];
   logic [4:0]   count_in [N];
   logic [N-1:0] active;
   logic [N-1:0] enable;

   // Channel order: back zones, back fail, front zones, front fail
   assign active = {fail_latch[1], front_zones, fail_latch[0], back_zones};
   assign enable = {{4{side.use_front}}, {4{side.use_back}}};

   // Clear while active, else count up and saturate at the threshold; a disabled side holds
   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (!enable[i]) begin
            count_in[i] = count_ff[i];
         end else if (active[i]) begin
            count_in[i] = 5'd0;
         end else if (count_ff[i] < threshold) begin
            count_in[i] = count_ff[i] + 5'd1;
         end else begin
            count_in[i] = threshold;
         end
         sensor_in[i] = count_in[i] < threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            count_ff[i] <= lzoq_pkg::HOLD_THRESHOLD_RESET;
         end
      end else if (accept) begin
         for (int i = 0; i < N; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

endmodule

/* hdl/lidar_zone_output_qualifier_top.sv */
// Lidar zone output qualifier. Every request (one scan tick) gives exactly one
// response, in the cycle after it is taken, and a request can be taken in every
// cycle: the only storage on the path is the single response register, and
// req_tready drops only while that register holds a response that the
// downstream side has not taken. Each response carries the held sensor bits,
// the debounced failure level, the sticky failure flags, the active-low area
// pins and the area-change strobes. Registers at csr byte address 0 (hold
// threshold, 5 bits) and 4 (sides enabled, 2 bits) should be written only while
// no response is outstanding; other addresses alias by address bit 2.
module lidar_zone_output_qualifier_top #(
   parameter int HISTORY_LEN = lzoq_pkg::HISTORY_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // [7:0] area_command, [10:8] back_zones, [13:11] front_zones,
   // [15:14] trouble_lines, [17:16] clear_latch, [23:18] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // [7:0] sensor_state, [9:8] failure_now, [11:10] fail_flags,
   // [15:12] back_area_pins, [20:16] front_area_pins, [22:21] area_changed,
   // [23] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                    accept;
   logic                    csr_write;
   logic [4:0]              threshold_ff;
   logic [1:0]              sides_ff;
   lzoq_pkg::side_ctrl_type side;
   logic [7:0]              sensor_in;
   logic [1:0]              failure_level_in;
   logic [1:0]              fail_latch_in;
   logic [3:0]              back_pins_in;
   logic [4:0]              front_pins_in;
   logic [1:0]              area_changed_in;
   logic                    rsp_tvalid_ff;
   logic [23:0]             rsp_tdata_ff;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= lzoq_pkg::HOLD_THRESHOLD_RESET;
         sides_ff     <= lzoq_pkg::SIDES_ENABLED_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            lzoq_pkg::REG_HOLD_THRESHOLD: threshold_ff <= csr_pwdata[4:0];
            lzoq_pkg::REG_SIDES_ENABLED:  sides_ff     <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         lzoq_pkg::REG_HOLD_THRESHOLD: csr_prdata = {27'd0, threshold_ff};
         lzoq_pkg::REG_SIDES_ENABLED:  csr_prdata = {30'd0, sides_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   assign side.use_back  = sides_ff[0];
   assign side.use_front = sides_ff[1];

   // Request handshake
   assign req_tready = ~rsp_tvalid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   lzoq_area u_area (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .side            (side),
      .area_command    (req_tdata[7:0]),
      .back_pins_in    (back_pins_in),
      .front_pins_in   (front_pins_in),
      .area_changed_in (area_changed_in)
   );

   lzoq_fail #(
      .HISTORY_LEN (HISTORY_LEN)
   ) u_fail (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .side             (side),
      .trouble_lines    (req_tdata[15:14]),
      .clear_latch      (req_tdata[17:16]),
      .failure_level_in (failure_level_in),
      .fail_latch_in    (fail_latch_in)
   );

   lzoq_hold u_hold (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .side        (side),
      .threshold   (threshold_ff),
      .back_zones  (req_tdata[10:8]),
      .front_zones (req_tdata[13:11]),
      .fail_latch  (fail_latch_in),
      .sensor_in   (sensor_in)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= {1'b0, area_changed_in, front_pins_in, back_pins_in,
                          fail_latch_in, failure_level_in, sensor_in};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // A taken request always shows a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("request taken without a response");

   // A back strobe means a real area was driven onto the back pins
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[21]) |-> (rsp_tdata[15:12] != 4'hF))
      else $error("back area strobe with no area driven");

   // Same for the front pins
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[22]) |-> (rsp_tdata[20:16] != 5'h1F))
      else $error("front area strobe with no area driven");

endmodule

/* test/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST             = lzoq_pkg::HISTORY_LEN_DEFAULT;
   localparam int BACK             = 0;
   localparam int FRONT            = 1;
   localparam int PHASES           = 8;
   localparam int PHASE_ITEMS      = 55;
   localparam int LONG_HOLD_CYCLES = 40;

   // Request and response layouts, lowest field last
   typedef struct packed {
      logic [5:0] pad;
      logic [1:0] clear_latch;
      logic [1:0] trouble_lines;
      logic [2:0] front_zones;
      logic [2:0] back_zones;
      logic [7:0] area_command;
   } tick_request_type;

   typedef struct packed {
      logic       pad;
      logic [1:0] area_changed;
      logic [4:0] front_area_pins;
      logic [3:0] back_area_pins;
      logic [1:0] fail_flags;
      logic [1:0] failure_now;
      logic [7:0] sensor_state;
   } tick_result_type;

   // One directed row; the expected fields only count where typed is set
   typedef struct packed {
      logic       typed;
      logic [7:0] cmd;
      logic [2:0] bz;
      logic [2:0] fz;
      logic [1:0] tr;
      logic [1:0] clr;
      logic [7:0] sensors;
      logic [1:0] fnow;
      logic [1:0] flags;
      logic [3:0] pb;
      logic [4:0] pf;
      logic [1:0] chg;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 18;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // first tick after reset: both areas written
      '{1'b1, 8'h00, 3'd0, 3'd0, 2'd0, 2'd0, 8'h00, 2'd0, 2'd0, 4'hE, 5'h1E, 2'd3},
      // all ones: back area 8, front wraps to area 1 (no change), zones held
      '{1'b1, 8'hFF, 3'd7, 3'd7, 2'd0, 2'd0, 8'h77, 2'd0, 2'd0, 4'h7, 5'h1E, 2'd1},
      '{1'b1, 8'hFF, 3'd0, 3'd0, 2'd0, 2'd0, 8'h77, 2'd0, 2'd0, 4'h7, 5'h1E, 2'd0},
      // eight ticks of trouble on both sides, front area 31
      '{1'b0, 8'hF7, 3'd1, 3'd2, 2'd3, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'hF7, 3'd0, 3'd0, 2'd3, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'hF7, 3'd0, 3'd0, 2'd3, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'h38, 3'd0, 3'd0, 2'd3, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'h38, 3'd0, 3'd0, 2'd3, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'h38, 3'd0, 3'd0, 2'd3, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'h38, 3'd0, 3'd0, 2'd3, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'h38, 3'd0, 3'd0, 2'd3, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      // clear while the history is still full: flag comes straight back
      '{1'b0, 8'h38, 3'd0, 3'd0, 2'd3, 2'd3, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      // clear with trouble gone: flags drop, level holds
      '{1'b0, 8'h40, 3'd4, 3'd4, 2'd0, 2'd3, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'h40, 3'd0, 3'd0, 2'd1, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'h08, 3'd2, 3'd1, 2'd2, 2'd1, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      // front code 31 wraps to area 1
      '{1'b0, 8'hF8, 3'd0, 3'd0, 2'd0, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'h07, 3'd0, 3'd0, 2'd0, 2'd0, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0},
      '{1'b0, 8'h00, 3'd0, 3'd0, 2'd0, 2'd2, 8'h00, 2'd0, 2'd0, 4'h0, 5'h00, 2'd0}
   };

   // Register settings per phase; idle odds 0 means no random idling
   localparam logic [4:0] PHASE_THRESHOLD [PHASES] = '{5'd31, 5'd4, 5'd0, 5'd31,
                                                       5'd12, 5'd20, 5'd1, 5'd25};
   localparam logic [1:0] PHASE_SIDES [PHASES] = '{2'd3, 2'd3, 2'd3, 2'd0,
                                                   2'd1, 2'd2, 2'd3, 2'd3};
   localparam int PHASE_IDLE_ODDS [PHASES] = '{6, 0, 4, 6, 3, 0, 5, 0};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow state of the qualifier
   logic [4:0]              hold_thr;
   lzoq_pkg::side_ctrl_type sides_cfg;
   logic [4:0]              hold_count [lzoq_pkg::NUM_CHANNELS];
   logic [HIST-1:0]         trouble_history [2];
   logic [1:0]              failure_level;
   logic [1:0]              sticky_flags;
   logic [7:0]              last_back_area;
   logic [7:0]              last_front_area;
   logic [3:0]              back_pins;
   logic [4:0]              front_pins;

   tick_result_type expected_ticks [$];
   int              mismatches = 0;
   int              idle_odds = 0;
   bit              long_hold_request = 1'b0;

   lidar_zone_output_qualifier_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void reset_shadow();
      int i;
      hold_thr = lzoq_pkg::HOLD_THRESHOLD_RESET;
      sides_cfg = lzoq_pkg::SIDES_ENABLED_RESET;
      for (i = 0; i < lzoq_pkg::NUM_CHANNELS; i++)
         hold_count[i] = lzoq_pkg::HOLD_THRESHOLD_RESET;
      trouble_history[BACK] = '0;
      trouble_history[FRONT] = '0;
      failure_level = '0;
      sticky_flags = '0;
      last_back_area = lzoq_pkg::AREA_NONE;
      last_front_area = lzoq_pkg::AREA_NONE;
      back_pins = lzoq_pkg::BACK_PINS_RESET;
      front_pins = lzoq_pkg::FRONT_PINS_RESET;
   endfunction

   // Off-delay counter: clears while active, counts up to the threshold
   function automatic void hold_tick(int ch, logic active);
      if (active)
         hold_count[ch] = '0;
      else if (hold_count[ch] < hold_thr)
         hold_count[ch] = hold_count[ch] + 5'd1;
      else
         hold_count[ch] = hold_thr;
   endfunction

   // Trouble debounce: full history sets level and sticky flag, empty clears level
   function automatic void shift_trouble(int side, logic pin);
      logic [HIST-1:0] h;
      h = {trouble_history[side][HIST-2:0], pin};
      trouble_history[side] = h;
      if (&h) begin
         sticky_flags[side] = 1'b1;
         failure_level[side] = 1'b1;
      end else if (h == '0) begin
         failure_level[side] = 1'b0;
      end
   endfunction

   function automatic tick_result_type qualify_scan_tick(input tick_request_type rq);
      tick_result_type res;
      logic [7:0]      area_back;
      logic [7:0]      area_front;
      int              i;
      res = '0;
      sticky_flags = sticky_flags & ~rq.clear_latch;

      area_back = {5'd0, rq.area_command[2:0]} + 8'd1;
      area_front = {3'd0, rq.area_command[7:3]} + 8'd1;
      if (area_front > lzoq_pkg::FRONT_AREA_MAX)
         area_front = 8'd1;
      if (area_back != last_back_area) begin
         if (sides_cfg.use_back) begin
            back_pins = ~area_back[3:0];
            res.area_changed[BACK] = 1'b1;
         end
         last_back_area = area_back;
      end
      if (area_front != last_front_area) begin
         if (sides_cfg.use_front) begin
            front_pins = ~area_front[4:0];
            res.area_changed[FRONT] = 1'b1;
         end
         last_front_area = area_front;
      end

      shift_trouble(BACK, sides_cfg.use_back & rq.trouble_lines[BACK]);
      shift_trouble(FRONT, sides_cfg.use_front & rq.trouble_lines[FRONT]);

      // counters of a disabled side stay frozen
      if (sides_cfg.use_back) begin
         for (i = 0; i < 3; i++)
            hold_tick(i, rq.back_zones[i]);
         hold_tick(3, sticky_flags[BACK]);
      end
      if (sides_cfg.use_front) begin
         for (i = 0; i < 3; i++)
            hold_tick(4 + i, rq.front_zones[i]);
         hold_tick(7, sticky_flags[FRONT]);
      end

      for (i = 0; i < lzoq_pkg::NUM_CHANNELS; i++)
         res.sensor_state[i] = (hold_count[i] < hold_thr);
      res.failure_now = failure_level;
      res.fail_flags = sticky_flags;
      res.back_area_pins = back_pins;
      res.front_area_pins = front_pins;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Driving helpers
   // ---------------------------------------------------------------------
   task automatic send_tick(input tick_request_type rq, input logic typed,
                            input tick_result_type typed_result);
      tick_result_type predicted;
      req_tvalid <= 1'b1;
      req_tdata <= rq;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = qualify_scan_tick(rq);
      expected_ticks.push_back(typed ? typed_result : predicted);
   endtask

   // APB write, then read back the same register; ends with the bus idle
   task automatic program_register(input logic reg_sel, input logic [31:0] value);
      logic [31:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == lzoq_pkg::REG_HOLD_THRESHOLD)
         hold_thr = value[4:0];
      else
         sides_cfg = value[1:0];
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value) begin
         $error("csr register %0d: expected %h, got %h", reg_sel, value, readback);
         mismatches++;
      end
      @(posedge clock);
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      tick_result_type got;
      tick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_ticks.size() == 0) begin
            $error("response %h with nothing expected", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_ticks.pop_front();
            check_field("sensor_state", want.sensor_state, got.sensor_state);
            check_field("failure_now", want.failure_now, got.failure_now);
            check_field("fail_flags", want.fail_flags, got.fail_flags);
            check_field("back_area_pins", want.back_area_pins, got.back_area_pins);
            check_field("front_area_pins", want.front_area_pins, got.front_area_pins);
            check_field("area_changed", want.area_changed, got.area_changed);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Downstream side: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      tick_request_type rq;
      tick_result_type  typed_result;
      stim_row_type     row;
      logic [7:0]       area_cmd;
      int               run_left [2];
      bit               run_noisy [2];
      bit               run_level [2];
      int               r;
      int               p;
      int               n;
      int               s;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      reset_shadow();
      area_cmd = 8'h00;
      run_left = '{0, 0};
      run_noisy = '{1'b0, 1'b0};
      run_level = '{1'b0, 1'b0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset settings
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED[r];
         rq = '0;
         rq.area_command = row.cmd;
         rq.back_zones = row.bz;
         rq.front_zones = row.fz;
         rq.trouble_lines = row.tr;
         rq.clear_latch = row.clr;
         typed_result = '0;
         typed_result.sensor_state = row.sensors;
         typed_result.failure_now = row.fnow;
         typed_result.fail_flags = row.flags;
         typed_result.back_area_pins = row.pb;
         typed_result.front_area_pins = row.pf;
         typed_result.area_changed = row.chg;
         send_tick(rq, row.typed, typed_result);
      end

      // random phases, each under its own register setting
      for (p = 0; p < PHASES; p++) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (expected_ticks.size() != 0);
         repeat (2) @(posedge clock);
         program_register(lzoq_pkg::REG_HOLD_THRESHOLD, {27'd0, PHASE_THRESHOLD[p]});
         program_register(lzoq_pkg::REG_SIDES_ENABLED, {30'd0, PHASE_SIDES[p]});
         idle_odds = PHASE_IDLE_ODDS[p];

         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 10)
               long_hold_request = 1'b1;
            if (p == 5 && n == 20) begin
               // let the pipe drain completely before going on
               req_tvalid <= 1'b0;
               do @(posedge clock); while (expected_ticks.size() != 0);
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 18)) @(posedge clock);
            end

            // area command mostly steady, now and then a new one or a wrapping front code
            if ($urandom_range(0, 5) == 0)
               area_cmd = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 19) == 0)
               area_cmd = {5'h1F, 3'($urandom_range(0, 7))};

            // trouble lines come in steady runs long enough to fill the history,
            // with short noisy stretches between
            rq = '0;
            for (s = 0; s < 2; s++) begin
               if (run_left[s] == 0) begin
                  run_noisy[s] = ($urandom_range(0, 3) == 0);
                  run_level[s] = 1'($urandom_range(0, 1));
                  run_left[s] = run_noisy[s] ? $urandom_range(1, 5) : $urandom_range(8, 14);
               end
               run_left[s]--;
               rq.trouble_lines[s] = run_noisy[s] ? 1'($urandom_range(0, 1)) : run_level[s];
            end

            rq.area_command = area_cmd;
            rq.back_zones = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
            rq.front_zones = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
            rq.clear_latch = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
            send_tick(rq, 1'b0, '0);
         end
      end

      // drain and report
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_ticks.size() != 0);
      repeat (4) @(posedge clock);
      if (mismatches == 0 && expected_ticks.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* sim.f */
hdl/lzoq_pkg.sv
hdl/lzoq_area.sv
hdl/lzoq_fail.sv
hdl/lzoq_hold.sv
hdl/lidar_zone_output_qualifier_top.sv
test/testbench.sv
